FILE: sv/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// No dependencies; simulation builds get the checks, synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

FILE: sv/efws_pkg.sv
// Package for the earliest-free worker scheduler: sizes, heap slot type,
// memory request struct and the sift pick codes. No dependencies.
`default_nettype none

package efws_pkg;

   localparam int MAX_WORKERS = 16;
   localparam int TIME_W      = 48;
   localparam int DUR_W       = 32;
   localparam int WORKER_W    = 4;
   localparam int COUNT_W     = 5;
   localparam int IDX_W       = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int LIVE_W      = $clog2(MAX_WORKERS + 1);
   localparam int CHILD_W     = $clog2(2 * MAX_WORKERS + 1);

   // One heap entry: finish time and worker index.
   typedef struct packed {
      logic [TIME_W-1:0] finish;
      logic [IDX_W-1:0]  worker;
   } slot_type;

   // Access request from the sequencer to the heap memory.
   typedef struct packed {
      logic [IDX_W-1:0] rd_addr_a;
      logic [IDX_W-1:0] rd_addr_b;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      slot_type         wr_data;
      logic             clear;
   } mem_req_type;

   // Which of the three candidates is earliest.
   typedef enum logic [1:0] {
      PICK_CUR,
      PICK_LEFT,
      PICK_RIGHT
   } pick_type;

endpackage

`default_nettype wire

FILE: sv/efws_heap_mem.sv
// Heap storage: one write port, two registered read ports, per-entry valid bits.
// Depends on efws_pkg. An entry never written since the last restart reads as
// worker <address>, free at time zero.
`default_nettype none

module efws_heap_mem (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire efws_pkg::mem_req_type mem_req,
   output efws_pkg::slot_type        rd_a,
   output efws_pkg::slot_type        rd_b
);
   import efws_pkg::*;

   slot_type               mem_ff [MAX_WORKERS];
   logic [MAX_WORKERS-1:0] valid_ff;
   slot_type               data_a_ff;
   slot_type               data_b_ff;
   logic                   valid_a_ff;
   logic                   valid_b_ff;
   logic [IDX_W-1:0]       addr_a_ff;
   logic [IDX_W-1:0]       addr_b_ff;

   // Memory array write and registered reads.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      data_a_ff <= mem_ff[mem_req.rd_addr_a];
      data_b_ff <= mem_ff[mem_req.rd_addr_b];
      addr_a_ff <= mem_req.rd_addr_a;
      addr_b_ff <= mem_req.rd_addr_b;
   end

   // Valid bits: a restart clears them all at once.
   always_ff @(posedge clock) begin
      if (reset || mem_req.clear) begin
         valid_ff   <= '0;
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            valid_ff[mem_req.wr_addr] <= 1'b1;
         end
         valid_a_ff <= valid_ff[mem_req.rd_addr_a];
         valid_b_ff <= valid_ff[mem_req.rd_addr_b];
      end
   end

   // Unwritten entries read as their restart value.
   always_comb begin
      rd_a = valid_a_ff ? data_a_ff : slot_type'{finish: '0, worker: addr_a_ff};
      rd_b = valid_b_ff ? data_b_ff : slot_type'{finish: '0, worker: addr_b_ff};
   end

endmodule

`default_nettype wire

FILE: sv/efws_sift_unit.sv
// Shared compare unit for one sift-down level: picks the earliest of the
// moving slot and its two children. Depends on efws_pkg.
`default_nettype none

module efws_sift_unit (
   input  wire efws_pkg::slot_type cur,
   input  wire efws_pkg::slot_type left,
   input  wire efws_pkg::slot_type right,
   input  wire logic               left_ok,
   input  wire logic               right_ok,
   output efws_pkg::pick_type      pick
);
   import efws_pkg::*;

   slot_type best_l;
   logic     left_wins;
   logic     right_wins;

   // Order on finish time, then on the lower worker index.
   function automatic logic slot_before(slot_type a, slot_type b);
      logic res;
      if (a.finish != b.finish) begin
         res = a.finish < b.finish;
      end else begin
         res = a.worker < b.worker;
      end
      return res;
   endfunction

   // Left child against the moving slot, then the right child against the winner.
   always_comb begin
      left_wins  = left_ok && slot_before(left, cur);
      best_l     = left_wins ? left : cur;
      right_wins = right_ok && slot_before(right, best_l);
      if (right_wins) begin
         pick = PICK_RIGHT;
      end else if (left_wins) begin
         pick = PICK_LEFT;
      end else begin
         pick = PICK_CUR;
      end
   end

endmodule

`default_nettype wire

FILE: sv/earliest_free_worker_scheduler_top.sv
// Top level of the earliest-free worker scheduler: sequencer, result register
// and worker count register. Depends on efws_pkg, efws_heap_mem, efws_sift_unit.
//
//   channel | direction | payload              | transfer when
//   req     | in        | req_duration         | req_valid && req_ready
//   rsp     | out       | rsp_worker, rsp_start_time | rsp_valid && rsp_ready
//   csr     | in        | csr_worker_count     | csr_valid && csr_ready
//
// A job passes through ST_ROOT, one ST_SIFT step for each heap level the sift-down visits
// (1 to 5 with sixteen workers) and ST_DONE; the single heap memory port pair visits one level at a time.
// Reset and a worker count write clear all heap valid bits at once.
// The result sits in an output register; a new job is taken while it waits,
// and a finished job waits for the register before the next one is taken.
`default_nettype none
`include "assert_macros.svh"

module earliest_free_worker_scheduler_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [efws_pkg::DUR_W-1:0]    req_duration,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [efws_pkg::WORKER_W-1:0]      rsp_worker,
   output logic [efws_pkg::TIME_W-1:0]        rsp_start_time,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [efws_pkg::COUNT_W-1:0]  csr_worker_count
);
   import efws_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROOT,
      ST_SIFT,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [LIVE_W-1:0]    live_ff, live_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   slot_type             cur_ff, cur_in;
   logic [DUR_W-1:0]     dur_ff, dur_in;
   logic [WORKER_W-1:0]  res_worker_ff, res_worker_in;
   logic [TIME_W-1:0]    res_start_ff, res_start_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORKER_W-1:0]  rsp_worker_ff, rsp_worker_in;
   logic [TIME_W-1:0]    rsp_start_ff, rsp_start_in;

   mem_req_type          mem_req;
   slot_type             rd_a;
   slot_type             rd_b;
   pick_type             pick;
   logic                 req_xfer;
   logic                 csr_xfer;
   logic [CHILD_W-1:0]   lidx;
   logic [CHILD_W-1:0]   ridx;
   logic [CHILD_W-1:0]   nlidx;
   logic                 left_ok;
   logic                 right_ok;
   logic [TIME_W:0]      fin_sum;
   logic [TIME_W-1:0]    fin_sat;
   logic [WORKER_W+IDX_W-1:0] worker_wide;
   logic [31:0]          count_ext;

   efws_heap_mem u_heap_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_a    (rd_a),
      .rd_b    (rd_b)
   );

   efws_sift_unit u_sift_unit (
      .cur      (cur_ff),
      .left     (rd_a),
      .right    (rd_b),
      .left_ok  (left_ok),
      .right_ok (right_ok),
      .pick     (pick)
   );

   // Handshakes; configuration takes precedence over a new job.
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign req_xfer  = req_valid && req_ready;
   assign csr_xfer  = csr_valid && csr_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_worker     = rsp_worker_ff;
   assign rsp_start_time = rsp_start_ff;

   // Children of the current position and whether they are live.
   always_comb begin
      lidx     = CHILD_W'({pos_ff, 1'b1});
      ridx     = lidx + CHILD_W'(1);
      left_ok  = lidx < CHILD_W'(live_ff);
      right_ok = ridx < CHILD_W'(live_ff);
   end

   // Saturating finish time and the narrowed worker field of the root.
   always_comb begin
      fin_sum     = {1'b0, rd_a.finish} + (TIME_W+1)'(dur_ff);
      fin_sat     = fin_sum[TIME_W] ? '1 : fin_sum[TIME_W-1:0];
      worker_wide = {{WORKER_W{1'b0}}, rd_a.worker};
      count_ext   = 32'(csr_worker_count);
   end

   // Sequencer next state and heap accesses.
   always_comb begin
      state_in      = state_ff;
      live_in       = live_ff;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      dur_in        = dur_ff;
      res_worker_in = res_worker_ff;
      res_start_in  = res_start_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_worker_in = rsp_worker_ff;
      rsp_start_in  = rsp_start_ff;
      mem_req       = '0;
      nlidx         = '0;

      case (state_ff)
         ST_IDLE: begin
            // Keep the root read going so it is ready after a transfer.
            mem_req.rd_addr_a = '0;
            if (csr_xfer) begin
               mem_req.clear = 1'b1;
               if (count_ext == 32'd0) begin
                  live_in = LIVE_W'(1);
               end else if (count_ext > 32'(MAX_WORKERS)) begin
                  live_in = LIVE_W'(MAX_WORKERS);
               end else begin
                  live_in = LIVE_W'(count_ext);
               end
            end else if (req_xfer) begin
               dur_in   = req_duration;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            // Root gives the result; its new finish time starts the sift-down.
            res_worker_in     = worker_wide[WORKER_W-1:0];
            res_start_in      = rd_a.finish;
            cur_in.finish     = fin_sat;
            cur_in.worker     = rd_a.worker;
            pos_in            = '0;
            mem_req.rd_addr_a = IDX_W'(1);
            mem_req.rd_addr_b = IDX_W'(2);
            state_in          = ST_SIFT;
         end
         ST_SIFT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff;
            case (pick)
               PICK_LEFT: begin
                  mem_req.wr_data = rd_a;
                  pos_in          = lidx[IDX_W-1:0];
               end
               PICK_RIGHT: begin
                  mem_req.wr_data = rd_b;
                  pos_in          = ridx[IDX_W-1:0];
               end
               default: begin
                  mem_req.wr_data = cur_ff;
                  state_in        = ST_DONE;
               end
            endcase
            nlidx             = CHILD_W'({pos_in, 1'b1});
            mem_req.rd_addr_a = nlidx[IDX_W-1:0];
            mem_req.rd_addr_b = IDX_W'(nlidx + CHILD_W'(1));
         end
         ST_DONE: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_worker_in = res_worker_ff;
               rsp_start_in  = res_start_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= LIVE_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      cur_ff        <= cur_in;
      dur_ff        <= dur_in;
      res_worker_ff <= res_worker_in;
      res_start_ff  <= res_start_in;
      rsp_worker_ff <= rsp_worker_in;
      rsp_start_ff  <= rsp_start_in;
   end

   // Checks on the sequencer and heap invariants.
   `ASSERT_CLK(a_accept_to_root, clock, reset, req_xfer |=> (state_ff == ST_ROOT), "no root read")
   `ASSERT_CLK(a_root_is_live, clock, reset, (state_ff == ST_ROOT) |-> (LIVE_W'(rd_a.worker) < live_ff), "root dead")
   `ASSERT_CLK(a_pos_is_live, clock, reset, (state_ff == ST_SIFT) |-> (LIVE_W'(pos_ff) < live_ff), "pos dead")
   `ASSERT_CLK(a_live_range, clock, reset, (live_ff != '0) && (live_ff <= LIVE_W'(MAX_WORKERS)), "bad count")
   `ASSERT_NEVER(a_no_dual_xfer, clock, reset, req_xfer && csr_xfer, "job and config in one cycle")

endmodule

`default_nettype wire
